// ===== design/md5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 shared definitions
// Payload types, command type, initial chaining values and round tables.
// ----------------------------------------------------------------------------
package md5_pkg;

  // One input item: a message byte and its framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       end_of_message;
  } item_t;

  // One result item: a digest word and its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } result_t;

  // Command passed from the front end to the hash engine
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_end;
  } cmd_t;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Last pad mark position that still leaves room for the length in the same block
  localparam logic [5:0] LAST_SHORT_POS = 6'd55;

  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
      2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
      default: idx = 4'(lo * 4'd7);
    endcase
    return idx;
  endfunction

  // Rotate amount used by a round
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    return ROT_AMOUNT[{rnd[5:4], rnd[1:0]}];
  endfunction

endpackage
`default_nettype wire

// ===== design/md5_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 front end
// Accepts input items, drops empty ones and queues the rest as commands.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_ready,
  output cmd_t  cmd
);

  localparam int IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slots [QueueDepth];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  // Flow control: take items while a slot is free
  assign item_ready = (count != CntW'(QueueDepth));
  assign push = item_valid && item_ready && (item.carries_byte || item.end_of_message);
  assign pop  = cmd_valid && cmd_ready;

  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];

  // Store the classified command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data_byte: item.data_byte,
                         has_byte:  item.carries_byte,
                         is_end:    item.end_of_message};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IdxW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/md5_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 hash engine
// Buffers message bytes, runs one compression round per cycle, pads the
// final block on the fly and presents the four digest words.
// ----------------------------------------------------------------------------
module md5_back import md5_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    digest_valid,
  input  logic    digest_ready,
  output result_t digest
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [6:0] FULL_BLOCK = 7'd64;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;

  logic [2:0]  state;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [60:0] byte_count;
  logic [6:0]  blk_fill;
  logic        blk_mark;
  logic        blk_len;
  logic        end_pending;
  logic [1:0]  word_idx;

  logic [31:0] buf_mem [16];
  logic [31:0] rd_data;
  logic [3:0]  rd_addr;

  logic [5:0]  pos;
  logic [5:0]  pad_pos;
  logic        take;
  logic [3:0]  cur_word;
  logic [31:0] w;
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] t_rot;

  assign cmd_ready = (state == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign pos       = byte_count[5:0];
  assign pad_pos   = cmd.has_byte ? pos + 1'b1 : pos;

  // Block buffer: byte-lane writes, registered word reads
  assign rd_addr = (state == ST_START) ? msg_index(6'd0) : msg_index(rnd + 1'b1);

  always_ff @(posedge clk) begin
    if (take && cmd.has_byte) begin
      buf_mem[pos[5:2]][8*pos[1:0] +: 8] <= cmd.data_byte;
    end
    rd_data <= buf_mem[rd_addr];
  end

  // Build the message word: buffered bytes, pad mark, zeros and length
  assign cur_word = msg_index(rnd);

  always_comb begin
    logic [6:0] p;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      p = {1'b0, cur_word, 2'(k)};
      if (p < blk_fill) begin
        w[8*k +: 8] = rd_data[8*k +: 8];
      end else if (blk_mark && (p == blk_fill)) begin
        w[8*k +: 8] = PAD_MARK;
      end else begin
        w[8*k +: 8] = 8'h00;
      end
    end
    if (blk_len && (cur_word == LEN_LO_WORD)) begin
      w = {byte_count[28:0], 3'b000};
    end else if (blk_len && (cur_word == LEN_HI_WORD)) begin
      w = byte_count[60:29];
    end
  end

  // Round function
  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign t     = a + f + w + ROUND_ADD[rnd];
  assign t_rot = {t, t} << rot_amount(rnd);

  // Digest output
  assign digest_valid = (state == ST_EMIT);
  assign digest = '{digest_word: chain[word_idx],
                    word_index:  word_idx,
                    last_word:   (word_idx == 2'd3)};

  // Working variables
  always_ff @(posedge clk) begin
    if (state == ST_START) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (state == ST_ROUND) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + t_rot[63:32];
    end
  end

  // Sequence commands, blocks and digest transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chain[0]    <= IV0;
      chain[1]    <= IV1;
      chain[2]    <= IV2;
      chain[3]    <= IV3;
      byte_count  <= '0;
      rnd         <= '0;
      blk_fill    <= '0;
      blk_mark    <= 1'b0;
      blk_len     <= 1'b0;
      end_pending <= 1'b0;
      word_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (cmd.has_byte) begin
              byte_count <= byte_count + 1'b1;
            end
            if (cmd.has_byte && (pos == 6'd63)) begin
              // full data block; padding follows if the message ends here
              blk_fill    <= FULL_BLOCK;
              blk_mark    <= 1'b0;
              blk_len     <= 1'b0;
              end_pending <= cmd.is_end;
              state       <= ST_START;
            end else if (cmd.is_end) begin
              // first padding block; a second one carries the length if no room
              blk_fill    <= {1'b0, pad_pos};
              blk_mark    <= 1'b1;
              blk_len     <= (pad_pos <= LAST_SHORT_POS);
              end_pending <= (pad_pos > LAST_SHORT_POS);
              state       <= ST_START;
            end
          end
        end
        ST_START: begin
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          if (blk_len) begin
            word_idx <= '0;
            state    <= ST_EMIT;
          end else if (end_pending) begin
            // trailing block: mark only if the previous block had none
            blk_fill    <= '0;
            blk_mark    <= !blk_mark;
            blk_len     <= 1'b1;
            end_pending <= 1'b0;
            state       <= ST_START;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (digest_ready) begin
            if (word_idx == 2'd3) begin
              chain[0]   <= IV0;
              chain[1]   <= IV1;
              chain[2]   <= IV2;
              chain[3]   <= IV3;
              byte_count <= '0;
              word_idx   <= '0;
              state      <= ST_IDLE;
            end else begin
              word_idx <= word_idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/md5_message_digest_unit.sv =====
// MD5 digest unit. Message bytes enter one per transfer on the item channel;
// an item with end_of_message set closes the message (after its byte, if it
// carries one) and the unit then delivers four 32-bit digest words, word 0
// first, with digest byte 0 in the low bits. Items with neither a byte nor
// the end flag are dropped. A byte that does not complete a 64-byte block
// is only buffered in the hash engine; each completed block runs 64 rounds
// of the single round unit plus load and chain update. Closing a message
// adds one padding block, or two when 56 or more bytes sit in the last block,
// then four digest transfers. A small command queue in front lets new items
// be taken while the engine is busy or waits on the digest channel.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 message digest unit
// Top level: front end, command queue and hash engine.
// ----------------------------------------------------------------------------
module md5_message_digest_unit import md5_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    digest_valid,
  input  logic    digest_ready,
  output result_t digest
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Classify and queue incoming items
  md5_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Hash queued commands and deliver the digest
  md5_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule
`default_nettype wire
